>>> src/lds_pkg.sv
`timescale 1ns / 1ps
package lds_pkg;

  localparam int NUM_ENTRIES = 4;
  localparam int REG_COUNT   = 4;

  localparam int TICKET_W   = 16;
  localparam int DRAW_W     = 31;
  localparam int WINS_W     = 32;
  localparam int OUT_SLOT_W = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int SLOT_IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int TOTAL_W    = TICKET_W + $clog2(NUM_ENTRIES + 1);
  localparam int BIT_CNT_W  = $clog2(DRAW_W);

  localparam logic [TICKET_W-1:0] RST_TICKETS_SLOT0 = TICKET_W'(300);
  localparam logic [TICKET_W-1:0] RST_TICKETS_SLOT1 = TICKET_W'(200);
  localparam logic [TICKET_W-1:0] RST_TICKETS_SLOT2 = TICKET_W'(100);
  localparam logic [TICKET_W-1:0] RST_TICKETS_SLOT3 = TICKET_W'(0);

  typedef logic [TICKET_W-1:0] ticket_t;
  typedef logic [WINS_W-1:0]   wins_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_e;

  function automatic ticket_t reset_tickets(input int slot);
    ticket_t val;
    case (slot)
      0:       val = RST_TICKETS_SLOT0;
      1:       val = RST_TICKETS_SLOT1;
      2:       val = RST_TICKETS_SLOT2;
      3:       val = RST_TICKETS_SLOT3;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> src/lottery_draw_scheduler_unit.sv
`timescale 1ns / 1ps
// Lottery draw scheduler. Each accepted word carries a 31-bit random draw; the
// block sums the slot ticket counts one slot per cycle, reduces the draw modulo
// that total with a bit-serial restoring divider (one draw bit per cycle), then
// walks the slots one per cycle to find the winner, bumps its saturating win
// counter and presents one result word, waiting in ST_DONE while the earlier
// result is not yet taken. A draw is accepted only in ST_IDLE, so no new draw is
// taken before the last one's result is loaded. With a zero ticket total the
// divide and walk are skipped and no_tickets is set with winner fields zero.
// Ticket registers are written through the cfg port; the user must write them
// only while no draw is in flight, as the block does not enforce this; indexes
// past the slot count are ignored.
module lottery_draw_scheduler_unit
  import lds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [TICKET_W-1:0]   cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DRAW_W-1:0]     random_value_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_SLOT_W-1:0] winner_slot_o,
  output logic [WINS_W-1:0]     winner_wins_o,
  output logic                  no_tickets_o
);

  state_e state_q, state_d;

  ticket_t tickets_q [NUM_ENTRIES];
  wins_t   wins_q [NUM_ENTRIES];
  wins_t   wins_d [NUM_ENTRIES];

  logic [DRAW_W-1:0]     draw_q, draw_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [TOTAL_W-1:0]    rem_q, rem_d;
  logic [TOTAL_W-1:0]    sum_q, sum_d;
  logic [SLOT_IDX_W-1:0] idx_q, idx_d;
  logic [BIT_CNT_W-1:0]  bit_q, bit_d;
  logic                  zero_q, zero_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_SLOT_W-1:0] out_slot_q, out_slot_d;
  wins_t                 out_wins_q, out_wins_d;
  logic                  out_zero_q, out_zero_d;

  logic [TOTAL_W-1:0] cur_ticket;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W-1:0] sum_next;
  logic               idx_last;
  wins_t              cur_wins;

  assign cur_ticket = TOTAL_W'(tickets_q[idx_q]);
  assign sum_next   = total_q + cur_ticket;
  assign trial      = {rem_q, draw_q[DRAW_W-1]};
  assign idx_last   = (idx_q == SLOT_IDX_W'(NUM_ENTRIES - 1));
  assign cur_wins   = wins_q[idx_q];

  always_comb begin
    state_d     = state_q;
    wins_d      = wins_q;
    draw_d      = draw_q;
    total_d     = total_q;
    rem_d       = rem_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_slot_d  = out_slot_q;
    out_wins_d  = out_wins_q;
    out_zero_d  = out_zero_q;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          draw_d  = random_value_i;
          total_d = '0;
          idx_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        total_d = sum_next;
        if (idx_last) begin
          idx_d  = '0;
          rem_d  = '0;
          bit_d  = '0;
          sum_d  = '0;
          zero_d = (sum_next == '0);
          state_d = (sum_next == '0) ? ST_DONE : ST_DIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIV: begin
        // restoring step: shift in the next draw bit, subtract if it fits
        if (trial >= {1'b0, total_q}) begin
          rem_d = TOTAL_W'(trial - {1'b0, total_q});
        end else begin
          rem_d = trial[TOTAL_W-1:0];
        end
        draw_d = draw_q << 1;
        bit_d  = bit_q + 1'b1;
        if (bit_q == BIT_CNT_W'(DRAW_W - 1)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        sum_d = sum_q + cur_ticket;
        if ((sum_q + cur_ticket) > rem_q || idx_last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_zero_d  = zero_q;
          if (zero_q) begin
            out_slot_d = '0;
            out_wins_d = '0;
          end else begin
            out_slot_d = OUT_SLOT_W'(idx_q);
            if (cur_wins == '1) begin
              out_wins_d = cur_wins;
            end else begin
              out_wins_d         = cur_wins + 1'b1;
              wins_d[idx_q]      = cur_wins + 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tickets_q[i] <= reset_tickets(i);
        wins_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wins_q      <= wins_d;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (i < REG_COUNT && cfg_we_i && cfg_index_i == CFG_IDX_W'(i)) begin
          tickets_q[i] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    draw_q     <= draw_d;
    total_q    <= total_d;
    rem_q      <= rem_d;
    sum_q      <= sum_d;
    idx_q      <= idx_d;
    bit_q      <= bit_d;
    zero_q     <= zero_d;
    out_slot_q <= out_slot_d;
    out_wins_q <= out_wins_d;
    out_zero_q <= out_zero_d;
  end

  assign out_valid_o   = out_valid_q;
  assign winner_slot_o = out_slot_q;
  assign winner_wins_o = out_wins_q;
  assign no_tickets_o  = out_zero_q;

endmodule
